FILE: rtl/dldm_pkg.sv
// shared types and constants of the doubly linked deque manager
package dldm_pkg;

  localparam int POOL_NODES_DEF = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam int OP_W       = 3;
  localparam int ITEM_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 4;
  localparam int COUNT_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_REM_VALUE = 3'd4,
    OP_SEARCH    = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

endpackage

FILE: rtl/dldm_ram.sv
// generic single write port ram with registered read
module dldm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/doubly_linked_deque_manager.sv
// Doubly linked list manager over a pool of POOL_NODES nodes kept in three small rams (value,
// next link, previous link) with a free map in flip-flops; a new node takes the lowest free
// slot. One word is worked on at a time, and the next one is taken while the last result
// still waits on the output register. Remove front or back reads the end node and unlinks
// it; an unknown operation, and a removal, search or remove by value on an empty list, go
// straight to the result. An insert scans the free map one slot a cycle for the lowest free
// slot, then writes the node and links it, or reports full once the last slot is scanned. A
// search walks the list, following one link a cycle through the shared read port of the node
// rams, for at most POOL_NODES nodes; a remove by value that matches adds the unlink step.
// A result still held on the output register holds the next result back until it is taken.
module doubly_linked_deque_manager
  import dldm_pkg::*;
#(
  parameter int POOL_NODES = POOL_NODES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OP_W-1:0]          operation_i,
  input  logic signed [ITEM_W-1:0] item_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic signed [ITEM_W-1:0] removed_value_o,
  output logic                     found_o,
  output logic [SLOT_OUT_W-1:0]    found_slot_o,
  output logic [COUNT_W-1:0]       entry_count_o
);

  localparam int IDX_W  = $clog2(POOL_NODES);
  localparam int SLOT_W = $clog2(POOL_NODES + 1);
  localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(POOL_NODES);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(POOL_NODES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_LINK,
    S_WALK,
    S_UNLINK,
    S_DONE
  } state_e;

  function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
    return s < NULL_SLOT;
  endfunction

  state_e                  state_q, state_d;
  logic [OP_W-1:0]         op_q, op_d;
  logic [VALUE_BITS-1:0]   val_q, val_d;
  logic [SLOT_W-1:0]       cur_q, cur_d;
  logic [IDX_W-1:0]        scan_q, scan_d;
  logic [SLOT_W-1:0]       steps_q, steps_d;
  logic [SLOT_W-1:0]       head_q, head_d;
  logic [SLOT_W-1:0]       tail_q, tail_d;
  logic [SLOT_W-1:0]       length_q, length_d;
  logic [POOL_NODES-1:0]   free_q, free_d;
  status_e                 res_status_q, res_status_d;
  logic [VALUE_BITS-1:0]   res_removed_q, res_removed_d;
  logic                    res_found_q, res_found_d;
  logic [IDX_W-1:0]        res_slot_q, res_slot_d;
  logic                    out_valid_q, out_valid_d;
  status_e                 out_status_q, out_status_d;
  logic [VALUE_BITS-1:0]   out_removed_q, out_removed_d;
  logic                    out_found_q, out_found_d;
  logic [IDX_W-1:0]        out_slot_q, out_slot_d;
  logic [SLOT_W-1:0]       out_count_q, out_count_d;

  logic [VALUE_BITS-1:0]   in_val;
  logic [SLOT_W-1:0]       end_slot;
  logic [SLOT_W-1:0]       steps_inc;

  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic                    val_we;
  logic [IDX_W-1:0]        val_waddr;
  logic [VALUE_BITS-1:0]   val_wdata;
  logic [VALUE_BITS-1:0]   val_rd;
  logic                    nxt_we;
  logic [IDX_W-1:0]        nxt_waddr;
  logic [SLOT_W-1:0]       nxt_wdata;
  logic [SLOT_W-1:0]       nxt_rd;
  logic                    prv_we;
  logic [IDX_W-1:0]        prv_waddr;
  logic [SLOT_W-1:0]       prv_wdata;
  logic [SLOT_W-1:0]       prv_rd;

  assign in_val    = VALUE_BITS'($unsigned(item_value_i));
  assign end_slot  = (operation_i == OP_REM_FRONT) ? head_q : tail_q;
  assign steps_inc = steps_q + 1'b1;

  dldm_ram #(.WIDTH(VALUE_BITS), .DEPTH(POOL_NODES)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (val_rd)
  );

  dldm_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_NODES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (nxt_rd)
  );

  dldm_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_NODES)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (prv_rd)
  );

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    val_d         = val_q;
    cur_d         = cur_q;
    scan_d        = scan_q;
    steps_d       = steps_q;
    head_d        = head_q;
    tail_d        = tail_q;
    length_d      = length_q;
    free_d        = free_q;
    res_status_d  = res_status_q;
    res_removed_d = res_removed_q;
    res_found_d   = res_found_q;
    res_slot_d    = res_slot_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_status_d  = out_status_q;
    out_removed_d = out_removed_q;
    out_found_d   = out_found_q;
    out_slot_d    = out_slot_q;
    out_count_d   = out_count_q;
    rd_en         = 1'b0;
    rd_addr       = '0;
    val_we        = 1'b0;
    val_waddr     = '0;
    val_wdata     = val_q;
    nxt_we        = 1'b0;
    nxt_waddr     = '0;
    nxt_wdata     = NULL_SLOT;
    prv_we        = 1'b0;
    prv_waddr     = '0;
    prv_wdata     = NULL_SLOT;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d          = operation_i;
          val_d         = in_val;
          cur_d         = NULL_SLOT;
          scan_d        = '0;
          steps_d       = '0;
          res_status_d  = ST_OK;
          res_removed_d = '0;
          res_found_d   = 1'b0;
          res_slot_d    = '0;
          case (operation_i)
            OP_INS_FRONT, OP_INS_BACK: begin
              state_d = S_ALLOC;
            end
            OP_REM_FRONT, OP_REM_BACK: begin
              if (slot_ok(end_slot)) begin
                cur_d   = end_slot;
                rd_en   = 1'b1;
                rd_addr = end_slot[IDX_W-1:0];
                state_d = S_UNLINK;
              end else begin
                res_status_d = ST_EMPTY;
                state_d      = S_DONE;
              end
            end
            OP_REM_VALUE, OP_SEARCH: begin
              if (slot_ok(head_q)) begin
                cur_d   = head_q;
                rd_en   = 1'b1;
                rd_addr = head_q[IDX_W-1:0];
                state_d = S_WALK;
              end else begin
                res_status_d = ST_NOT_FOUND;
                state_d      = S_DONE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_ALLOC: begin
        if (free_q[scan_q]) begin
          cur_d          = SLOT_W'(scan_q);
          free_d[scan_q] = 1'b0;
          val_we         = 1'b1;
          val_waddr      = scan_q;
          nxt_we         = 1'b1;
          nxt_waddr      = scan_q;
          nxt_wdata      = (op_q == OP_INS_FRONT) ? head_q : NULL_SLOT;
          prv_we         = 1'b1;
          prv_waddr      = scan_q;
          prv_wdata      = (op_q == OP_INS_FRONT) ? NULL_SLOT : tail_q;
          state_d        = S_LINK;
        end else if (scan_q == LAST_IDX) begin
          res_status_d = ST_FULL;
          state_d      = S_DONE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_LINK: begin
        if (op_q == OP_INS_FRONT) begin
          if (slot_ok(head_q)) begin
            prv_we    = 1'b1;
            prv_waddr = head_q[IDX_W-1:0];
            prv_wdata = cur_q;
          end else begin
            tail_d = cur_q;
          end
          head_d = cur_q;
        end else begin
          if (slot_ok(tail_q)) begin
            nxt_we    = 1'b1;
            nxt_waddr = tail_q[IDX_W-1:0];
            nxt_wdata = cur_q;
          end else begin
            head_d = cur_q;
          end
          tail_d = cur_q;
        end
        length_d = length_q + 1'b1;
        state_d  = S_DONE;
      end
      S_WALK: begin
        if (val_rd == val_q) begin
          res_found_d = 1'b1;
          res_slot_d  = cur_q[IDX_W-1:0];
          state_d     = (op_q == OP_REM_VALUE) ? S_UNLINK : S_DONE;
        end else if (steps_inc == NULL_SLOT || !slot_ok(nxt_rd)) begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_DONE;
        end else begin
          steps_d = steps_inc;
          cur_d   = nxt_rd;
          rd_en   = 1'b1;
          rd_addr = nxt_rd[IDX_W-1:0];
        end
      end
      S_UNLINK: begin
        res_removed_d = val_rd;
        if (slot_ok(prv_rd)) begin
          nxt_we    = 1'b1;
          nxt_waddr = prv_rd[IDX_W-1:0];
          nxt_wdata = nxt_rd;
        end else begin
          head_d = nxt_rd;
        end
        if (slot_ok(nxt_rd)) begin
          prv_we    = 1'b1;
          prv_waddr = nxt_rd[IDX_W-1:0];
          prv_wdata = prv_rd;
        end else begin
          tail_d = prv_rd;
        end
        free_d[cur_q[IDX_W-1:0]] = 1'b1;
        length_d = length_q - 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_status_d  = res_status_q;
          out_removed_d = res_removed_q;
          out_found_d   = res_found_q;
          out_slot_d    = res_slot_q;
          out_count_d   = length_q;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      op_q          <= '0;
      val_q         <= '0;
      cur_q         <= NULL_SLOT;
      scan_q        <= '0;
      steps_q       <= '0;
      head_q        <= NULL_SLOT;
      tail_q        <= NULL_SLOT;
      length_q      <= '0;
      free_q        <= '1;
      res_status_q  <= ST_OK;
      res_removed_q <= '0;
      res_found_q   <= 1'b0;
      res_slot_q    <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= ST_OK;
      out_removed_q <= '0;
      out_found_q   <= 1'b0;
      out_slot_q    <= '0;
      out_count_q   <= '0;
    end else begin
      state_q       <= state_d;
      op_q          <= op_d;
      val_q         <= val_d;
      cur_q         <= cur_d;
      scan_q        <= scan_d;
      steps_q       <= steps_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      length_q      <= length_d;
      free_q        <= free_d;
      res_status_q  <= res_status_d;
      res_removed_q <= res_removed_d;
      res_found_q   <= res_found_d;
      res_slot_q    <= res_slot_d;
      out_valid_q   <= out_valid_d;
      out_status_q  <= out_status_d;
      out_removed_q <= out_removed_d;
      out_found_q   <= out_found_d;
      out_slot_q    <= out_slot_d;
      out_count_q   <= out_count_d;
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign removed_value_o = $signed(ITEM_W'(out_removed_q));
  assign found_o         = out_found_q;
  assign found_slot_o    = SLOT_OUT_W'(out_slot_q);
  assign entry_count_o   = COUNT_W'(out_count_q);

  // list bookkeeping stays consistent between words
  a_head_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((head_q == NULL_SLOT) == (length_q == '0)))
    else $error("head and length disagree");

  a_tail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((tail_q == NULL_SLOT) == (length_q == '0)))
    else $error("tail and length disagree");

  a_free_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(free_q) + int'(length_q) == POOL_NODES))
    else $error("free map and length disagree");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (status_o == ST_OK))
    else $error("match reported with error status");

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the doubly linked deque manager
`timescale 1ns / 1ps

module testbench;
  import dldm_pkg::*;

  localparam int POOL = POOL_NODES_DEF;
  localparam logic [COUNT_W-1:0] NIL = 5'd16;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [ITEM_W-1:0] val;
  } word_t;

  typedef struct {
    status_e                  status;
    logic signed [ITEM_W-1:0] removed;
    logic                     found;
    logic [SLOT_OUT_W-1:0]    slot;
    logic [COUNT_W-1:0]       entries;
  } outcome_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [OP_W-1:0]          operation_i = '0;
  logic signed [ITEM_W-1:0] item_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [STATUS_W-1:0]      status_o;
  logic signed [ITEM_W-1:0] removed_value_o;
  logic                     found_o;
  logic [SLOT_OUT_W-1:0]    found_slot_o;
  logic [COUNT_W-1:0]       entry_count_o;

  // model of the node pool
  logic [ITEM_W-1:0]  pool_val  [POOL];
  logic [COUNT_W-1:0] link_next [POOL];
  logic [COUNT_W-1:0] link_prev [POOL];
  logic [POOL-1:0]    slot_free = '1;
  logic [COUNT_W-1:0] head = NIL;
  logic [COUNT_W-1:0] tail = NIL;
  logic [COUNT_W-1:0] live_nodes = '0;

  word_t    word_q [$];
  outcome_t outcome_q [$];
  word_t    next_word;
  outcome_t want;
  logic     in_taken = 1'b0;
  logic     calm = 1'b0;
  logic     hold_done = 1'b0;
  int       words_in = 0;
  int       tx_gap = 0;
  int       rx_gap = 0;
  int       hold_left = 0;
  int       idle_cycles = 0;
  int       fail_count = 0;

  doubly_linked_deque_manager DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .item_value_i   (item_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .found_o        (found_o),
    .found_slot_o   (found_slot_o),
    .entry_count_o  (entry_count_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void unlink_node(logic [COUNT_W-1:0] s);
    logic [COUNT_W-1:0] p;
    logic [COUNT_W-1:0] n;
    p = link_prev[s];
    n = link_next[s];
    if (p != NIL) link_next[p] = n;
    else head = n;
    if (n != NIL) link_prev[n] = p;
    else tail = p;
    link_next[s] = NIL;
    link_prev[s] = NIL;
    slot_free[s] = 1'b1;
    live_nodes--;
  endfunction

  function automatic outcome_t deque_step(logic [OP_W-1:0] op, logic [ITEM_W-1:0] v);
    outcome_t r;
    logic [COUNT_W-1:0] s;
    logic [COUNT_W-1:0] hit;
    int k;
    r.status = ST_OK;
    r.removed = '0;
    r.found = 1'b0;
    r.slot = '0;
    s = NIL;
    hit = NIL;
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        for (k = POOL - 1; k >= 0; k--) if (slot_free[k]) s = k[COUNT_W-1:0];
        if (s == NIL) begin
          r.status = ST_FULL;
        end else begin
          slot_free[s] = 1'b0;
          pool_val[s] = v;
          if (op == OP_INS_FRONT) begin
            link_prev[s] = NIL;
            link_next[s] = head;
            if (head != NIL) link_prev[head] = s;
            else tail = s;
            head = s;
          end else begin
            link_next[s] = NIL;
            link_prev[s] = tail;
            if (tail != NIL) link_next[tail] = s;
            else head = s;
            tail = s;
          end
          live_nodes++;
        end
      end
      OP_REM_FRONT, OP_REM_BACK: begin
        s = (op == OP_REM_FRONT) ? head : tail;
        if (s == NIL) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed = pool_val[s];
          unlink_node(s);
        end
      end
      OP_REM_VALUE, OP_SEARCH: begin
        s = head;
        for (k = 0; k < POOL && s != NIL && hit == NIL; k++) begin
          if (pool_val[s] == v) hit = s;
          else s = link_next[s];
        end
        if (hit == NIL) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found = 1'b1;
          r.slot = hit[SLOT_OUT_W-1:0];
          if (op == OP_REM_VALUE) begin
            r.removed = pool_val[hit];
            unlink_node(hit);
          end
        end
      end
      default: ;
    endcase
    r.entries = live_nodes;
    return r;
  endfunction

  task automatic push_word(logic [OP_W-1:0] op, logic [ITEM_W-1:0] v);
    word_t w;
    w.op = op;
    w.val = v;
    word_q.push_back(w);
  endtask

  function automatic logic [ITEM_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 7) - 3;
    if (r < 7) begin
      case ($urandom_range(0, 3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  // fill leans on inserts, drain on removals, mixed is even
  function automatic logic [OP_W-1:0] pick_op(int mode);
    int unsigned r;
    int unsigned ins_cut;
    int unsigned rem_cut;
    r = $urandom_range(0, 99);
    ins_cut = (mode == 0) ? 75 : (mode == 1) ? 20 : 35;
    rem_cut = (mode == 0) ? 85 : (mode == 1) ? 70 : 65;
    if (r < ins_cut) return $urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK;
    if (r < rem_cut) return $urandom_range(0, 1) ? OP_REM_FRONT : OP_REM_BACK;
    if (r < 98) return $urandom_range(0, 1) ? OP_REM_VALUE : OP_SEARCH;
    return $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
  endfunction

  task automatic check_field(string name, logic [ITEM_W-1:0] exp_v, logic [ITEM_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // sender
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (word_q.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
        tx_gap = $urandom_range(0, 12);
        in_valid_i <= 1'b0;
      end else if (word_q.size() != 0) begin
        next_word = word_q.pop_front();
        in_valid_i <= 1'b1;
        operation_i <= next_word.op;
        item_value_i <= next_word.val;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && words_in >= 150) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_ready_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      rx_gap = $urandom_range(0, 12);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // prediction, checking and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      calm <= word_q.size() < 120;
      if (in_valid_i && in_ready_o) begin
        outcome_q.push_back(deque_step(operation_i, item_value_i));
        words_in++;
      end
      if (out_valid_o && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result word, status %0d", $time, status_o);
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          check_field("status", want.status, status_o);
          check_field("removed_value", want.removed, removed_value_o);
          check_field("found", want.found, found_o);
          check_field("found_slot", want.slot, found_slot_o);
          check_field("entry_count", want.entries, entry_count_o);
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[doubly_linked_deque_manager] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int ph;
    int i;
    int mode;
    // empty list, spare codes
    push_word(OP_REM_FRONT, 32'h0);
    push_word(OP_REM_BACK, 32'h0);
    push_word(OP_SEARCH, 32'h5);
    push_word(OP_REM_VALUE, 32'h5);
    push_word(OP_SPARE_6, 32'h0);
    push_word(OP_SPARE_7, 32'hffff_ffff);
    // value extremes, duplicates and first-match
    push_word(OP_INS_FRONT, 32'h7fff_ffff);
    push_word(OP_INS_BACK, 32'h8000_0000);
    push_word(OP_INS_FRONT, 32'h0);
    push_word(OP_INS_BACK, 32'hffff_ffff);
    push_word(OP_INS_FRONT, 32'h0);
    push_word(OP_SEARCH, 32'h8000_0000);
    push_word(OP_SEARCH, 32'h0);
    push_word(OP_SEARCH, 32'h1234_5678);
    push_word(OP_REM_VALUE, 32'h0);
    push_word(OP_REM_VALUE, 32'h7fff_ffff);
    push_word(OP_REM_VALUE, 32'h0);
    push_word(OP_REM_FRONT, 32'h0);
    push_word(OP_REM_BACK, 32'h0);
    push_word(OP_REM_BACK, 32'h0);
    push_word(OP_INS_BACK, 32'h5555_5555);
    push_word(OP_INS_FRONT, 32'haaaa_aaaa);
    for (ph = 0; ph < 20; ph++) begin
      mode = $urandom_range(0, 2);
      for (i = 0; i < 50; i++) push_word(pick_op(mode), pick_value());
    end

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (word_q.size() != 0 || in_valid_i || outcome_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[doubly_linked_deque_manager] OK");
    end else begin
      $display("[doubly_linked_deque_manager] ERROR");
    end
    $finish;
  end

endmodule

FILE: doubly_linked_deque_manager.f
rtl/dldm_pkg.sv
rtl/dldm_ram.sv
rtl/doubly_linked_deque_manager.sv
tb/testbench.sv
